[src/ibe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ibe_pkg;

  // Character positions inside YYYYMMDDTHHMMSS,fffffffff
  localparam logic [4:0] YEAR_END   = 5'd3;
  localparam logic [4:0] MONTH_END  = 5'd5;
  localparam logic [4:0] DAY_END    = 5'd7;
  localparam logic [4:0] DATE_SEP   = 5'd8;
  localparam logic [4:0] HOUR_END   = 5'd10;
  localparam logic [4:0] MINUTE_END = 5'd12;
  localparam logic [4:0] SECOND_END = 5'd14;
  localparam logic [4:0] FRAC_SEP   = 5'd15;
  localparam logic [4:0] FRAC_START = 5'd16;
  localparam logic [4:0] MAX_CHARS  = 5'd25;

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  localparam logic [13:0] EPOCH_YEAR = 14'd1970;
  // leaps_through(1969) = 492 - 19 + 4
  localparam logic [23:0] EPOCH_LEAPS = 24'd477;

  // x / 25 for x < 4096: (x * 5243) >> 17
  localparam logic [12:0] DIV25_MUL   = 13'd5243;
  localparam int          DIV25_SHIFT = 17;

  localparam logic [29:0] NANOS_LIMIT = 30'd1000000000;

  // Snapshot of one parsed string, handed from the parser to the converter
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] fraction;
    logic [4:0]  count;
    logic        err;
  } ibe_stamp_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [26:0] pow10(input logic [3:0] k);
    logic [26:0] p;
    case (k)
      4'd1:    p = 27'd10;
      4'd2:    p = 27'd100;
      4'd3:    p = 27'd1000;
      4'd4:    p = 27'd10000;
      4'd5:    p = 27'd100000;
      4'd6:    p = 27'd1000000;
      4'd7:    p = 27'd10000000;
      4'd8:    p = 27'd100000000;
      default: p = 27'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[src/iso8601_basic_to_epoch.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result path: the last character transfer of a string passes the queue, then the
//   3-stage converter (decode/multiply, day-count, seconds output register) to m_tvalid.
// Throughput: one character per cycle while the queue is not full; a string of any length,
//   even one character, can follow in the next cycle; m_tready stalls fill the queue.
// Reset (rst, synchronous, active high): clears the parser state, empties the queue and
//   drops any result in flight.

module iso8601_basic_to_epoch import ibe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // last character of the string
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [37:0] epoch_seconds, [67:38] nanoseconds, zero pad
  output logic             m_tuser    // [0] parse_error
);

  // Parser front end: gathers digits into fields, one character per transfer.
  // On the last character it hands a complete snapshot to the queue.
  logic       take;
  logic       push;
  ibe_stamp_t stamp;

  // Queue between parser and converter; full stalls the character stream.
  logic       q_full;
  logic       q_not_empty;
  logic       pop;
  ibe_stamp_t head;

  // Converter results
  logic [37:0] epoch_seconds;
  logic [29:0] nanoseconds;
  logic        parse_error;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  ibe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (s_tdata),
    .last      (s_tlast),
    .stamp     (stamp),
    .push      (push)
  );

  ibe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (stamp),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Converter back end: fills defaults for missing fields, counts days with
  // Gregorian leap years and scales the fraction to nanoseconds.
  ibe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (q_not_empty),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .epoch_seconds (epoch_seconds),
    .nanoseconds   (nanoseconds),
    .parse_error   (parse_error)
  );

  // Pack the result fields, lowest field first
  assign m_tdata = {4'b0, nanoseconds, epoch_seconds};
  assign m_tuser = parse_error;

endmodule

`default_nettype wire

[src/ibe_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibe_front import ibe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  output ibe_stamp_t      stamp,
  output logic            push
);

  logic [4:0]  pos;
  logic [13:0] year;
  logic [6:0]  month, day, hour, minute, second;
  logic [29:0] fraction;
  logic        err;
  logic        field_bad;

  logic [4:0]  pos_next;
  logic [13:0] year_next;
  logic [6:0]  month_next, day_next, hour_next, minute_next, second_next;
  logic [29:0] fraction_next;
  logic        err_next;
  logic        field_bad_next;

  logic       digit;
  logic [3:0] d;
  logic       plain;

  assign digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign d     = digit ? 4'(char_code - CHAR_ZERO) : 4'd0;

  always_comb begin
    pos_next       = pos;
    year_next      = year;
    month_next     = month;
    day_next       = day;
    hour_next      = hour;
    minute_next    = minute;
    second_next    = second;
    fraction_next  = fraction;
    err_next       = err;
    field_bad_next = field_bad;
    plain          = 1'b1;
    if (take && (pos < MAX_CHARS)) begin
      // Times ten as shift-and-add, wrapping at the field width
      if (pos <= YEAR_END) begin
        year_next = {year[10:0], 3'b0} + {year[12:0], 1'b0} + 14'(d);
      end else if (pos <= MONTH_END) begin
        month_next = {month[3:0], 3'b0} + {month[5:0], 1'b0} + 7'(d);
      end else if (pos <= DAY_END) begin
        day_next = {day[3:0], 3'b0} + {day[5:0], 1'b0} + 7'(d);
      end else if ((pos == DATE_SEP) || (pos == FRAC_SEP)) begin
        plain = 1'b0;
      end else if (pos <= HOUR_END) begin
        hour_next = {hour[3:0], 3'b0} + {hour[5:0], 1'b0} + 7'(d);
      end else if (pos <= MINUTE_END) begin
        minute_next = {minute[3:0], 3'b0} + {minute[5:0], 1'b0} + 7'(d);
      end else if (pos <= SECOND_END) begin
        second_next = {second[3:0], 3'b0} + {second[5:0], 1'b0} + 7'(d);
      end else begin
        plain = 1'b0;
        fraction_next = {fraction[26:0], 3'b0} + {fraction[28:0], 1'b0} + 30'(d);
        if (!digit) begin
          err_next = 1'b1;
        end
      end
      if (plain && !digit) begin
        field_bad_next = 1'b1;
      end
      // A bad digit in a date or time field only counts once its field is complete
      if ((pos == YEAR_END) || (pos == MONTH_END) || (pos == DAY_END) ||
          (pos == HOUR_END) || (pos == MINUTE_END) || (pos == SECOND_END)) begin
        if (field_bad_next) begin
          err_next = 1'b1;
        end
        field_bad_next = 1'b0;
      end
      pos_next = pos + 5'd1;
    end
  end

  assign push = take && last;

  always_comb begin
    stamp.year     = year_next;
    stamp.month    = month_next;
    stamp.day      = day_next;
    stamp.hour     = hour_next;
    stamp.minute   = minute_next;
    stamp.second   = second_next;
    stamp.fraction = fraction_next;
    stamp.count    = pos_next;
    stamp.err      = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos       <= '0;
      year      <= '0;
      month     <= '0;
      day       <= '0;
      hour      <= '0;
      minute    <= '0;
      second    <= '0;
      fraction  <= '0;
      err       <= 1'b0;
      field_bad <= 1'b0;
    end else begin
      pos       <= pos_next;
      year      <= year_next;
      month     <= month_next;
      day       <= day_next;
      hour      <= hour_next;
      minute    <= minute_next;
      second    <= second_next;
      fraction  <= fraction_next;
      err       <= err_next;
      field_bad <= field_bad_next;
    end
  end

endmodule

`default_nettype wire

[src/ibe_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibe_queue import ibe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire ibe_stamp_t push_data,
  input  wire logic       pop,
  output ibe_stamp_t      head,
  output logic            not_empty,
  output logic            full
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ibe_stamp_t    slots [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == FULL_CNT);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

[src/ibe_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibe_back import ibe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ibe_stamp_t  head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [37:0]      epoch_seconds,
  output logic [29:0]      nanoseconds,
  output logic             parse_error
);

  logic adv;

  // Stage 1 registers
  logic        s1_valid;
  logic [13:0] s1_year;
  logic        s1_after_epoch;
  logic [7:0]  s1_q100m1;
  logic [7:0]  s1_q400m1;
  logic [7:0]  s1_q100y;
  logic [6:0]  s1_month, s1_day, s1_hour, s1_minute, s1_second;
  logic        s1_err;
  logic [29:0] s1_nanos;

  // Stage 2 registers
  logic        s2_valid;
  logic [23:0] s2_days;
  logic [18:0] s2_hms;
  logic        s2_err;
  logic [29:0] s2_nanos;

  // Stage 1 combinational
  logic [13:0] year_sel, ym1;
  logic [6:0]  month_sel, day_sel, hour_sel, minute_sel, second_sel;
  logic        err_sel;
  logic [3:0]  scale_idx;
  logic [56:0] nanos_prod;
  logic [24:0] p100m1, p400m1, p100y;

  assign adv = !out_valid || out_ready;
  assign pop = head_valid && adv;

  always_comb begin
    year_sel   = (head.count > YEAR_END)   ? head.year   : EPOCH_YEAR;
    month_sel  = (head.count > MONTH_END)  ? head.month  : 7'd1;
    day_sel    = (head.count > DAY_END)    ? head.day    : 7'd1;
    hour_sel   = (head.count > HOUR_END)   ? head.hour   : 7'd0;
    minute_sel = (head.count > MINUTE_END) ? head.minute : 7'd0;
    second_sel = (head.count > SECOND_END) ? head.second : 7'd0;
    err_sel    = head.err || (month_sel > 7'd12) || (day_sel == 7'd0);
    // Pad missing fraction digits with zeros on the right
    scale_idx  = (head.count > FRAC_START) ? 4'(MAX_CHARS - head.count) : 4'd0;
    nanos_prod = 57'(head.fraction) * 57'(pow10(scale_idx));
    ym1        = year_sel - 14'd1;
    p100m1     = 25'(ym1[13:2]) * 25'(DIV25_MUL);
    p400m1     = 25'(ym1[13:4]) * 25'(DIV25_MUL);
    p100y      = 25'(year_sel[13:2]) * 25'(DIV25_MUL);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_year        <= year_sel;
      s1_after_epoch <= year_sel > EPOCH_YEAR;
      s1_q100m1      <= p100m1[DIV25_SHIFT +: 8];
      s1_q400m1      <= p400m1[DIV25_SHIFT +: 8];
      s1_q100y       <= p100y[DIV25_SHIFT +: 8];
      s1_month       <= month_sel;
      s1_day         <= day_sel;
      s1_hour        <= hour_sel;
      s1_minute      <= minute_sel;
      s1_second      <= second_sel;
      s1_err         <= err_sel;
      s1_nanos       <= nanos_prod[29:0];
    end
  end

  // Stage 2 combinational
  logic [13:0] s1_ym1, s1_yoff;
  logic [14:0] q100y_x100;
  logic        leap;
  logic [23:0] leaps_m1;
  logic [23:0] year_days;
  logic [23:0] days;
  logic [18:0] hms;

  always_comb begin
    s1_ym1     = s1_year - 14'd1;
    s1_yoff    = s1_year - EPOCH_YEAR;
    q100y_x100 = {1'b0, s1_q100y, 6'b0} + {2'b0, s1_q100y, 5'b0} + {5'b0, s1_q100y, 2'b0};
    leap       = (s1_year[1:0] == 2'b00) &&
                 ((15'(s1_year) != q100y_x100) || (s1_q100y[1:0] == 2'b00));
    leaps_m1   = 24'(s1_ym1[13:2]) - 24'(s1_q100m1) + 24'(s1_q400m1);
    year_days  = s1_after_epoch ?
                 (24'(s1_yoff) * 24'd365 + leaps_m1 - EPOCH_LEAPS) : 24'd0;
    days       = year_days + 24'(days_before_month(s1_month[3:0]))
               + 24'((s1_month > 7'd2) && leap) + 24'(s1_day) - 24'd1;
    hms        = 19'(s1_hour) * 19'd3600 + 19'(s1_minute) * 19'd60 + 19'(s1_second);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_days  <= days;
      s2_hms   <= hms;
      s2_err   <= s1_err;
      s2_nanos <= s1_nanos;
    end
  end

  // Stage 3: output register
  logic [40:0] secs;
  assign secs = 41'(s2_days) * 41'd86400 + 41'(s2_hms);

  always_ff @(posedge clk) begin
    if (adv) begin
      epoch_seconds <= s2_err ? 38'd0 : secs[37:0];
      nanoseconds   <= s2_err ? 30'd0 : s2_nanos;
      parse_error   <= s2_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  a_nanos_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !parse_error) |-> (nanoseconds < NANOS_LIMIT))
    else $error("nanoseconds out of range");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && adv) |=> out_valid)
    else $error("result lost between stage 2 and output");

endmodule

`default_nettype wire

[dv/iso8601_basic_to_epoch_tb.sv]
`timescale 1ns / 1ps

module iso8601_basic_to_epoch_tb;
  import ibe_pkg::*;

  // One character transfer as the driver presents it
  typedef struct packed {
    logic       last;
    logic [7:0] code;
  } char_xfer_t;

  // One conversion result as the block should deliver it
  typedef struct packed {
    logic [37:0] secs;
    logic [29:0] nanos;
    logic        bad;
  } stamp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;

  iso8601_basic_to_epoch uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Characters waiting to be driven, and conversions waiting to come out
  char_xfer_t    char_q[$];
  stamp_result_t pending_stamps[$];
  logic [7:0]    text_q[$];
  char_xfer_t    next_char;

  int send_pct = 0;
  int recv_pct = 0;
  int chars_queued = 0;
  int mismatch_count = 0;

  // Parser copy kept by the testbench, advanced on every accepted character
  logic [4:0]  char_pos;
  logic [13:0] acc_year;
  logic [6:0]  acc_month;
  logic [6:0]  acc_day;
  logic [6:0]  acc_hour;
  logic [6:0]  acc_minute;
  logic [6:0]  acc_second;
  logic [29:0] acc_frac;
  logic        err_seen;
  logic        field_bad;

  task automatic clear_parser();
    char_pos   = '0;
    acc_year   = '0;
    acc_month  = '0;
    acc_day    = '0;
    acc_hour   = '0;
    acc_minute = '0;
    acc_second = '0;
    acc_frac   = '0;
    err_seen   = 1'b0;
    field_bad  = 1'b0;
  endtask

  initial clear_parser();

  // Gregorian leap days in years 1..y
  function automatic longint unsigned leap_count(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Fold one accepted character into the parser copy; on the last character
  // work out the conversion and queue it.
  task automatic absorb_char(input logic [7:0] c, input logic is_last);
    logic              is_digit;
    logic [3:0]        d;
    logic              bad;
    int unsigned       n;
    int unsigned       yv;
    int unsigned       mv;
    int unsigned       dv;
    int unsigned       hv;
    int unsigned       minv;
    int unsigned       sv;
    int unsigned       digits;
    longint unsigned   days;
    longint unsigned   secs;
    longint unsigned   nanos;
    stamp_result_t     res;
    if (char_pos < MAX_CHARS) begin
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
      if (char_pos <= YEAR_END) begin
        acc_year = acc_year * 10 + d;
      end else if (char_pos <= MONTH_END) begin
        acc_month = acc_month * 10 + d;
      end else if (char_pos <= DAY_END) begin
        acc_day = acc_day * 10 + d;
      end else if (char_pos == DATE_SEP || char_pos == FRAC_SEP) begin
        // separators are never examined
      end else if (char_pos <= HOUR_END) begin
        acc_hour = acc_hour * 10 + d;
      end else if (char_pos <= MINUTE_END) begin
        acc_minute = acc_minute * 10 + d;
      end else if (char_pos <= SECOND_END) begin
        acc_second = acc_second * 10 + d;
      end else begin
        // every fraction digit present is used, so a bad one is fatal at once
        acc_frac = acc_frac * 10 + d;
        if (!is_digit) err_seen = 1'b1;
      end
      // a bad digit in a date/time field only matters once the field completes
      if (!is_digit && char_pos != DATE_SEP && char_pos < FRAC_SEP) field_bad = 1'b1;
      if (char_pos == YEAR_END || char_pos == MONTH_END || char_pos == DAY_END ||
          char_pos == HOUR_END || char_pos == MINUTE_END || char_pos == SECOND_END) begin
        if (field_bad) err_seen = 1'b1;
        field_bad = 1'b0;
      end
      char_pos = char_pos + 5'd1;
    end

    if (is_last) begin
      n    = char_pos;
      yv   = (n >= 4)  ? acc_year   : EPOCH_YEAR;
      mv   = (n >= 6)  ? acc_month  : 1;
      dv   = (n >= 8)  ? acc_day    : 1;
      hv   = (n >= 11) ? acc_hour   : 0;
      minv = (n >= 13) ? acc_minute : 0;
      sv   = (n >= 15) ? acc_second : 0;
      bad  = err_seen || mv > 12 || dv == 0;
      // pad the fraction with zeros on the right up to nine digits
      nanos = 0;
      if (n > FRAC_START) begin
        digits = n - FRAC_START;
        if (digits > 9) digits = 9;
        nanos = acc_frac;
        repeat (9 - digits) nanos = nanos * 10;
      end
      if (bad) begin
        res.secs  = '0;
        res.nanos = '0;
        res.bad   = 1'b1;
      end else begin
        days = 0;
        // years before the epoch contribute nothing
        if (yv > EPOCH_YEAR)
          days = longint'(yv - EPOCH_YEAR) * 365 + leap_count(yv - 1) -
                 leap_count(EPOCH_YEAR - 1);
        case (mv)
          2:       days += 31;
          3:       days += 59;
          4:       days += 90;
          5:       days += 120;
          6:       days += 151;
          7:       days += 181;
          8:       days += 212;
          9:       days += 243;
          10:      days += 273;
          11:      days += 304;
          12:      days += 334;
          default: days += 0;
        endcase
        if (mv > 2 && ((yv % 400 == 0) || (yv % 4 == 0 && yv % 100 != 0))) days += 1;
        days += dv - 1;
        secs = days * 86400 + longint'(hv) * 3600 + longint'(minv) * 60 + sv;
        res.secs  = secs[37:0];
        res.nanos = nanos[29:0];
        res.bad   = 1'b0;
      end
      pending_stamps.push_back(res);
      clear_parser();
    end
  endtask

  // Driver: when the slot is free, present the next character or idle at random as the
  // phase asks; hold it until accepted, and predict each transfer at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_char(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          next_char = char_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_char.code;
          s_tlast  <= next_char.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag(input string what, input logic [71:0] want, input logic [71:0] got);
    // cap the log; the count still decides the verdict
    if (mismatch_count < 40)
      $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic check_stamp();
    stamp_result_t want;
    if (pending_stamps.size() == 0) begin
      flag("unexpected result", 72'd0, m_tdata);
    end else begin
      want = pending_stamps.pop_front();
      if (m_tdata[37:0] !== want.secs) flag("epoch_seconds", 72'(want.secs), 72'(m_tdata[37:0]));
      if (m_tdata[67:38] !== want.nanos)
        flag("nanoseconds", 72'(want.nanos), 72'(m_tdata[67:38]));
      if (m_tuser !== want.bad) flag("parse_error", 72'(want.bad), 72'(m_tuser));
      if (m_tdata[71:68] !== 4'd0) flag("tdata pad", 72'd0, 72'(m_tdata[71:68]));
    end
  endtask

  // Monitor: stall at random as the phase asks and check each result transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_pct);
      if (m_tvalid && m_tready) check_stamp();
    end
  end

  // Move the gathered text into the character queue, marking its final byte
  task automatic flush_text();
    char_xfer_t item;
    for (int i = 0; i < text_q.size(); i++) begin
      item.code = text_q[i];
      item.last = (i == text_q.size() - 1);
      char_q.push_back(item);
    end
    chars_queued += text_q.size();
    text_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    flush_text();
  endtask

  task automatic put_num(input int unsigned value, input int unsigned width);
    int unsigned scale;
    logic [7:0]  ch;
    scale = 1;
    for (int i = 1; i < width; i++) scale *= 10;
    for (int i = 0; i < width; i++) begin
      ch = CHAR_ZERO + 8'((value / scale) % 10);
      text_q.push_back(ch);
      scale /= 10;
    end
  endtask

  // Random timestamp: mostly well-formed with random content, sometimes cut
  // short, overlong or corrupted, and now and then pure byte noise.
  task automatic gen_stamp();
    int unsigned kind;
    int unsigned cut;
    int unsigned idx;
    kind = $urandom_range(99);
    text_q.delete();
    if (kind < 12) begin
      repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      put_num(($urandom_range(3) == 0) ? $urandom_range(9999) : $urandom_range(1960, 2110), 4);
      put_num(($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12), 2);
      put_num(($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31), 2);
      text_q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : "T");
      put_num(($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(23), 2);
      put_num($urandom_range(59), 2);
      put_num($urandom_range(60), 2);
      text_q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : ",");
      put_num($urandom_range(999999999), 9);
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 35) begin
        cut = $urandom_range(1, 24);
        while (text_q.size() > cut) text_q.delete(text_q.size() - 1);
      end
      if ($urandom_range(9) == 0) begin
        idx = $urandom_range(text_q.size() - 1);
        text_q[idx] = 8'($urandom_range(255));
      end
    end
    flush_text();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 59; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 59; end
        default: begin send_pct = 22; recv_pct = 22; end
      endcase
      chars_queued = 0;
      if (ph == 0) begin
        add_text("19700101T000000,000000000");    // the epoch itself
        add_text("99991231T235959,999999999");    // largest of everything
        add_text("1");                            // one character, all defaults
        add_text("2024");                         // year only
        add_text("196912");                       // before the epoch, month still counts
        add_text("20000229T12");                  // leap day, hour finished
        add_text("20241301");                     // month above 12
        add_text("20240100");                     // day zero
        add_text("20240001T99");                  // month zero, hour out of range
        add_text("20240161");                     // day out of range
        add_text("2024x");                        // bad digit in unfinished month
        add_text("20x4");                         // bad digit in finished year
        add_text("20240101T000000,");             // comma with no fraction
        add_text("20240101T000000,12a");          // bad fraction digit
        add_text("20240101T000000,123456789012"); // past the last position
      end
      while (chars_queued < 475) gen_stamp();
      // drain fully before changing the idle pattern
      while (char_q.size() != 0 || s_tvalid || pending_stamps.size() != 0) @(negedge clk);
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_stamps.size() == 0)
      $display("iso8601_basic_to_epoch_tb: clean");
    else
      $display("iso8601_basic_to_epoch_tb: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5000000;
    $display("iso8601_basic_to_epoch_tb: errors");
    $finish;
  end

endmodule

[sim.f]
src/ibe_pkg.sv
src/ibe_front.sv
src/ibe_queue.sv
src/ibe_back.sv
src/iso8601_basic_to_epoch.sv
dv/iso8601_basic_to_epoch_tb.sv
